FILE: hdl/saw_arq_pkg.sv
`default_nettype none

package saw_arq_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned CodeW = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_SEGMENT = 2'd1,
    OP_REPLY   = 2'd2,
    OP_POLL    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_HDR_WAIT  = 2'd1,
    PH_READY     = 2'd2,
    PH_DATA_WAIT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SEND   = 3'd1,
    ACT_RESEND = 3'd2,
    ACT_ACKED  = 3'd3,
    ACT_REJECT = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_MESSAGE = 2'd1,
    KIND_TAIL    = 2'd2
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLL_LIMIT   = 2'd0,
    REG_HEADER_CODE  = 2'd1,
    REG_MESSAGE_CODE = 2'd2
  } reg_index_t;

  localparam logic [CodeW-1:0] PollLimitReset   = 8'd10;
  localparam logic [CodeW-1:0] HeaderCodeReset  = 8'd8;
  localparam logic [CodeW-1:0] MessageCodeReset = 8'd7;

  typedef struct packed {
    logic [CodeW-1:0] poll_limit;
    logic [CodeW-1:0] header_reply_code;
    logic [CodeW-1:0] message_reply_code;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             is_last;
    logic [CodeW-1:0] reply_type;
    logic [SeqW-1:0]  reply_ack;
    logic             checksum_good;
  } item_t;

  typedef struct packed {
    logic [SeqW-1:0]  next_sequence;
    logic [SeqW-1:0]  expected_ack;
    phase_t           phase;
    logic [CodeW-1:0] empty_polls;
    kind_t            pending_kind;
    logic [SeqW-1:0]  pending_sequence;
  } arq_state_t;

  typedef struct packed {
    action_t          action;
    kind_t            packet_kind;
    logic [SeqW-1:0]  packet_seq;
    logic [SeqW-1:0]  expected_ack_out;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/saw_arq_in_if.sv
`default_nettype none

interface saw_arq_in_if import saw_arq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic                    is_last;
  logic [CodeW-1:0]        reply_type;
  logic signed [SeqW-1:0]  reply_ack;
  logic                    checksum_good;

  modport source (output valid, op, is_last, reply_type, reply_ack, checksum_good,
                  input ready);
  modport sink (input valid, op, is_last, reply_type, reply_ack, checksum_good,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/saw_arq_out_if.sv
`default_nettype none

interface saw_arq_out_if import saw_arq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [1:0]              packet_kind;
  logic signed [SeqW-1:0]  packet_seq;
  logic signed [SeqW-1:0]  expected_ack_out;

  modport source (output valid, action, packet_kind, packet_seq, expected_ack_out,
                  input ready);
  modport sink (input valid, action, packet_kind, packet_seq, expected_ack_out,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/saw_arq_step.sv
`default_nettype none

module saw_arq_step import saw_arq_pkg::*; (
  input  arq_state_t st,
  input  cfg_t       cfg,
  input  item_t      item,
  output arq_state_t st_next,
  output result_t    res
);

  logic [CodeW:0] poll_cnt;
  logic           poll_over;
  logic           ack_match;
  logic           hdr_match;
  logic           msg_match;
  kind_t          seg_kind;

  assign poll_cnt  = {1'b0, st.empty_polls} + {{CodeW{1'b0}}, 1'b1};
  assign poll_over = poll_cnt > {1'b0, cfg.poll_limit};
  assign ack_match = item.checksum_good && (item.reply_ack == st.expected_ack);
  assign hdr_match = ack_match && (item.reply_type == cfg.header_reply_code);
  assign msg_match = ack_match && (item.reply_type == cfg.message_reply_code);
  assign seg_kind  = item.is_last ? KIND_TAIL : KIND_MESSAGE;

  // next state
  always_comb begin
    st_next = st;
    case (item.op)
      OP_START: begin
        if (st.phase == PH_IDLE) begin
          st_next.pending_kind     = KIND_HEADER;
          st_next.pending_sequence = st.next_sequence;
          st_next.next_sequence    = st.next_sequence + {{(SeqW-1){1'b0}}, 1'b1};
          st_next.empty_polls      = '0;
          st_next.phase            = PH_HDR_WAIT;
        end
      end
      OP_SEGMENT: begin
        if (st.phase == PH_READY) begin
          st_next.pending_kind     = seg_kind;
          st_next.pending_sequence = st.next_sequence;
          st_next.next_sequence    = st.next_sequence + {{(SeqW-1){1'b0}}, 1'b1};
          st_next.empty_polls      = '0;
          st_next.phase            = PH_DATA_WAIT;
        end
      end
      OP_REPLY: begin
        if (st.phase == PH_HDR_WAIT && hdr_match) begin
          st_next.expected_ack = st.expected_ack + {{(SeqW-1){1'b0}}, 1'b1};
          st_next.phase        = PH_READY;
        end else if (st.phase == PH_DATA_WAIT) begin
          st_next.empty_polls = '0;
          if (msg_match) begin
            st_next.expected_ack = st.expected_ack + {{(SeqW-1){1'b0}}, 1'b1};
            st_next.phase = (st.pending_kind == KIND_TAIL) ? PH_IDLE : PH_READY;
          end
        end
      end
      OP_POLL: begin
        if (st.phase == PH_DATA_WAIT) begin
          st_next.empty_polls = poll_over ? '0 : poll_cnt[CodeW-1:0];
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // result
  always_comb begin
    res.action           = ACT_NONE;
    res.packet_kind      = KIND_HEADER;
    res.packet_seq       = '0;
    res.expected_ack_out = st_next.expected_ack;
    case (item.op)
      OP_START: begin
        if (st.phase == PH_IDLE) begin
          res.action     = ACT_SEND;
          res.packet_seq = st.next_sequence;
        end else begin
          res.action = ACT_REJECT;
        end
      end
      OP_SEGMENT: begin
        if (st.phase == PH_READY) begin
          res.action      = ACT_SEND;
          res.packet_kind = seg_kind;
          res.packet_seq  = st.next_sequence;
        end else begin
          res.action = ACT_REJECT;
        end
      end
      OP_REPLY: begin
        if ((st.phase == PH_HDR_WAIT && hdr_match) || st.phase == PH_DATA_WAIT) begin
          res.action      = (st.phase == PH_DATA_WAIT && !msg_match) ? ACT_RESEND
                                                                     : ACT_ACKED;
          res.packet_kind = st.pending_kind;
          res.packet_seq  = st.pending_sequence;
        end
      end
      OP_POLL: begin
        if (st.phase == PH_DATA_WAIT && poll_over) begin
          res.action      = ACT_RESEND;
          res.packet_kind = st.pending_kind;
          res.packet_seq  = st.pending_sequence;
        end
      end
      default: begin
        res.action = ACT_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/stop_and_wait_arq_sender.sv
`default_nettype none

// channel   | modport | payload
// ----------+---------+--------------------------------------------------------
// items     | sink    | op, is_last, reply_type, reply_ack, checksum_good
// results   | source  | action, packet_kind, packet_seq, expected_ack_out
// cfg_*     | write   | cfg_we, cfg_index, cfg_data (8 bit registers)
//
// one transaction per cycle sustained while results.ready is high; an item
// passes the input register, then step logic into the result register
// rst is synchronous and clears the counters, phase and valid flags
// a stalled result register holds the input register; items.ready drops once
// that holds an item, so an empty one still takes one more transaction

module stop_and_wait_arq_sender import saw_arq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CodeW-1:0]   cfg_data,
  saw_arq_in_if.sink              items,
  saw_arq_out_if.source           results
);

  cfg_t       cfg;
  arq_state_t st;
  arq_state_t st_next;
  item_t      item;
  result_t    res;
  logic       item_valid;
  logic       out_valid;
  result_t    out_res;
  logic       advance;

  assign advance     = item_valid && (!out_valid || results.ready);
  assign items.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_limit         <= PollLimitReset;
      cfg.header_reply_code  <= HeaderCodeReset;
      cfg.message_reply_code <= MessageCodeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLL_LIMIT:   cfg.poll_limit         <= cfg_data;
        REG_HEADER_CODE:  cfg.header_reply_code  <= cfg_data;
        REG_MESSAGE_CODE: cfg.message_reply_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item.op            <= op_t'(items.op);
      item.is_last       <= items.is_last;
      item.reply_type    <= items.reply_type;
      item.reply_ack     <= items.reply_ack;
      item.checksum_good <= items.checksum_good;
    end
  end

  saw_arq_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.next_sequence    <= '0;
      st.expected_ack     <= '0;
      st.phase            <= PH_IDLE;
      st.empty_polls      <= '0;
      st.pending_kind     <= KIND_HEADER;
      st.pending_sequence <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign results.valid            = out_valid;
  assign results.action           = out_res.action;
  assign results.packet_kind      = out_res.packet_kind;
  assign results.packet_seq       = out_res.packet_seq;
  assign results.expected_ack_out = out_res.expected_ack_out;

`ifndef NO_ASSERTIONS
  a_send_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.action == ACT_SEND |->
      st.next_sequence == out_res.packet_seq + {{(SeqW-1){1'b0}}, 1'b1})
    else $error("sent sequence does not match next_sequence");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.action == ACT_NONE || out_res.action == ACT_REJECT) |->
      out_res.packet_kind == KIND_HEADER && out_res.packet_seq == '0)
    else $error("packet fields set on a result without a packet");

  a_ack_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && st.expected_ack != $past(st.expected_ack) |->
      out_valid && out_res.action == ACT_ACKED)
    else $error("expected_ack moved without an acknowledge result");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> item_valid && out_valid && !results.ready)
    else $error("input stalled while the pipeline can move");
`endif

endmodule

`default_nettype wire
